FILE: sv/teis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teis_pkg
// Shared constants, command codes and the controller/datapath signal bundles.
// ----------------------------------------------------------------------------
package teis_pkg;

  localparam int TABLE_DEPTH_DEF   = 1024;
  localparam int FRACTION_BITS_DEF = 24;

  localparam logic [23:0] MASS_RESET = 24'd939566;
  localparam logic [31:0] MAG_MAX    = 32'h7FFF_FFFF;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  typedef enum logic [2:0] {
    MUL_TGT = 3'd0,
    MUL_Q   = 3'd1,
    MUL_CT  = 3'd2,
    MUL_MAG = 3'd3,
    MUL_X   = 3'd4,
    MUL_Y   = 3'd5,
    MUL_Z   = 3'd6
  } mul_sel_t;

  typedef enum logic {
    SQ_SRC_Q  = 1'b0,
    SQ_SRC_TH = 1'b1
  } sq_src_t;

  typedef struct packed {
    logic     cap;
    logic     append;
    logic     clear;
    logic     srch_init;
    logic     srch_upd;
    logic     sel_ld;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sq_start;
    sq_src_t  sq_src;
    logic     p_ld;
    logic     p_sat;
    logic     st_ld;
    logic     mag_ld;
    logic     sc_start;
    logic     x_ld;
    logic     y_ld;
    logic     z_ld;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic lo_eq_hi;
    logic q_big;
    logic sq_busy;
    logic sc_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/tabulated_energy_isotropic_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabulated_energy_isotropic_sampler
// Spectrum-line table with inverse-CDF energy choice and isotropic momentum.
// ----------------------------------------------------------------------------
// Input words carry a function code in in_tuser: append a line, clear the
// table, or draw a sample. Append and clear give no output and leave the
// block ready for the next word. A sample binary-searches the running sums
// (a table read, then a compare, per halving), then runs two 32-step square
// roots on one shared unit while a sine/cosine unit works alongside, and
// finishes through one shared multiplier. When the momentum saturates the
// first square root is skipped. A sample from an empty table goes straight
// to the output with the flag set.
// in_tready is high only while the block is between samples.
// Results sit in an output register: while the receiver stalls, append and
// clear words are still taken, and a finished sample waits for the register.
// Reset empties the table and sets the mass register to its default; table
// entries need no clearing, since only entries below the line count are read.
// cfg_wr_en writes particle_mass in any cycle; write it only while idle.
// ----------------------------------------------------------------------------
module tabulated_energy_isotropic_sampler #(
  parameter int TABLE_DEPTH   = teis_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = teis_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // line_weight[15:0], line_energy[39:16], rnd_energy[63:40],
  // rnd_cos[87:64], rnd_phi[111:88]
  input  logic [111:0] in_tdata,
  // func[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // mom_x[31:0], mom_y[63:32], mom_z[95:64], chosen_energy[119:96]
  output logic [119:0] out_tdata,
  // table_empty[0]
  output logic [0:0]   out_tuser
);

  import teis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  teis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  teis_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // An empty-table result carries no momentum and no energy.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("empty-table result with nonzero payload");

  // Taking a sample word drops in_tready, since the block leaves idle.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_SAMPLE |=> !in_tready)
    else $error("ready right after a sample was taken");

  // Append, clear and unused codes leave in_tready high in the cycle after they are taken.
  a_update_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != FUNC_SAMPLE |=> in_tready)
    else $error("table update did not finish in one cycle");

endmodule

FILE: sv/teis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teis_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module teis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/teis_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teis_sqrt
// Integer square root of a 64-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module teis_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [63:0] trial;
  logic        fits;

  assign trial = res_r + bit_r;
  assign fits  = rem_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= radicand;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[31:0];

endmodule

FILE: sv/teis_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teis_sincos
// Sine and cosine of a phase in turns, Q30, by a Taylor series to the 16th power.
// ----------------------------------------------------------------------------
module teis_sincos (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] phase,
  output logic        busy,
  output logic [31:0] cos_q30,
  output logic [31:0] sin_q30
);

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [1:0]  PH_ANGLE = 2'd0;
  localparam logic [1:0]  PH_MUL   = 2'd1;
  localparam logic [1:0]  PH_DIV   = 2'd2;
  localparam logic [1:0]  PH_ACC   = 2'd3;

  logic               busy_r;
  logic [1:0]         step_r;
  logic [1:0]         quad_r;
  logic [29:0]        r_r;
  logic [30:0]        a_r;
  logic [31:0]        t_r;
  logic [62:0]        m1_r;
  logic [31:0]        x_r;
  logic [67:0]        m2_r;
  logic signed [33:0] c_r;
  logic signed [33:0] s_r;
  logic [4:0]         k_r;
  logic [31:0]        cos_r;
  logic [31:0]        sin_r;

  logic [3:0]         kidx;
  logic [31:0]        q0;
  logic [31:0]        rem;
  logic [31:0]        tq;
  logic signed [33:0] tq_s;
  logic signed [33:0] c_nxt;
  logic signed [33:0] s_nxt;
  logic [30:0]        c_cl;
  logic [30:0]        s_cl;

  // floor(2^35 / k) for k = 1 .. 16; the division by k becomes a multiply.
  function automatic logic [35:0] recip(input logic [3:0] idx);
    logic [35:0] res;
    unique case (idx)
      4'd0:  res = 36'd34359738368;
      4'd1:  res = 36'd17179869184;
      4'd2:  res = 36'd11453246122;
      4'd3:  res = 36'd8589934592;
      4'd4:  res = 36'd6871947673;
      4'd5:  res = 36'd5726623061;
      4'd6:  res = 36'd4908534052;
      4'd7:  res = 36'd4294967296;
      4'd8:  res = 36'd3817748707;
      4'd9:  res = 36'd3435973836;
      4'd10: res = 36'd3123612578;
      4'd11: res = 36'd2863311530;
      4'd12: res = 36'd2643056797;
      4'd13: res = 36'd2454267026;
      4'd14: res = 36'd2290649224;
      4'd15: res = 36'd2147483648;
    endcase
    return res;
  endfunction

  function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
    logic [30:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > 34'sd1073741824) begin
      res = 31'd1073741824;
    end else begin
      res = v[30:0];
    end
    return res;
  endfunction

  always_comb begin
    kidx  = 4'(k_r - 5'd1);
    q0    = m2_r[66:35];
    rem   = x_r - 32'(q0 * 32'(k_r));
    tq    = (rem >= 32'(k_r)) ? q0 + 32'd1 : q0;
    tq_s  = 34'(signed'({2'b00, tq}));
    c_nxt = c_r;
    s_nxt = s_r;
    unique case (k_r[1:0])
      2'd1:    s_nxt = s_r + tq_s;
      2'd3:    s_nxt = s_r - tq_s;
      2'd0:    c_nxt = c_r + tq_s;
      default: c_nxt = c_r - tq_s;
    endcase
    c_cl = clamp_q30(c_nxt);
    s_cl = clamp_q30(s_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= PH_ANGLE;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= PH_ANGLE;
    end else if (busy_r) begin
      unique case (step_r)
        PH_ANGLE: step_r <= PH_MUL;
        PH_MUL:   step_r <= PH_DIV;
        PH_DIV:   step_r <= PH_ACC;
        PH_ACC: begin
          step_r <= PH_MUL;
          if (k_r == 5'd16) begin
            busy_r <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad_r <= phase[31:30];
      r_r    <= phase[29:0];
    end else if (busy_r) begin
      unique case (step_r)
        PH_ANGLE: begin
          a_r <= 31'((61'(r_r) * 61'(HALF_PI_Q30)) >> 30);
          t_r <= 32'd1073741824;
          c_r <= 34'sd1073741824;
          s_r <= '0;
          k_r <= 5'd1;
        end
        PH_MUL: begin
          m1_r <= 63'(t_r) * 63'(a_r);
        end
        PH_DIV: begin
          x_r  <= m1_r[61:30];
          m2_r <= 68'(m1_r[61:30]) * 68'(recip(kidx));
        end
        PH_ACC: begin
          t_r <= tq;
          c_r <= c_nxt;
          s_r <= s_nxt;
          k_r <= k_r + 5'd1;
          if (k_r == 5'd16) begin
            unique case (quad_r)
              2'd0: begin
                cos_r <= {1'b0, c_cl};
                sin_r <= {1'b0, s_cl};
              end
              2'd1: begin
                cos_r <= -{1'b0, s_cl};
                sin_r <= {1'b0, c_cl};
              end
              2'd2: begin
                cos_r <= -{1'b0, c_cl};
                sin_r <= -{1'b0, s_cl};
              end
              default: begin
                cos_r <= {1'b0, s_cl};
                sin_r <= -{1'b0, c_cl};
              end
            endcase
          end
        end
      endcase
    end
  end

  assign busy    = busy_r;
  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule

FILE: sv/teis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teis_ctrl
// Sequencer for table updates and the steps of one sample.
// ----------------------------------------------------------------------------
module teis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  input  teis_pkg::sts_t    sts,
  output teis_pkg::cmd_t    cmd
);

  import teis_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_TGT      = 22'h000002,
    S_SRCH_RD  = 22'h000004,
    S_SRCH_CMP = 22'h000008,
    S_SEL_LD   = 22'h000010,
    S_Q_MUL    = 22'h000020,
    S_Q_CHK    = 22'h000040,
    S_SQ_P     = 22'h000080,
    S_CT_MUL   = 22'h000100,
    S_CT_SQ    = 22'h000200,
    S_SQ_T     = 22'h000400,
    S_MAG_MUL  = 22'h000800,
    S_MAG_RND  = 22'h001000,
    S_SC_WAIT  = 22'h002000,
    S_X_MUL    = 22'h004000,
    S_X_RND    = 22'h008000,
    S_Y_MUL    = 22'h010000,
    S_Y_RND    = 22'h020000,
    S_Z_MUL    = 22'h040000,
    S_Z_RND    = 22'h080000,
    S_DONE     = 22'h100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_TGT;
    cmd.sq_src  = SQ_SRC_Q;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap    = 1'b1;
          cmd.append = (in_tuser == FUNC_APPEND);
          cmd.clear  = (in_tuser == FUNC_CLEAR);
          if (in_tuser == FUNC_SAMPLE) begin
            // An empty table answers at once with the flag set.
            state_nxt = sts.count_zero ? S_DONE : S_TGT;
          end
        end
      end
      S_TGT: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_TGT;
        cmd.srch_init = 1'b1;
        cmd.sc_start  = 1'b1;
        state_nxt     = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        // The read issued here is at lo once the range has closed.
        state_nxt = sts.lo_eq_hi ? S_SEL_LD : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH_RD;
      end
      S_SEL_LD: begin
        cmd.sel_ld = 1'b1;
        state_nxt  = S_Q_MUL;
      end
      S_Q_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Q;
        state_nxt   = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (sts.q_big) begin
          cmd.p_sat = 1'b1;
          state_nxt = S_CT_MUL;
        end else begin
          cmd.sq_start = 1'b1;
          cmd.sq_src   = SQ_SRC_Q;
          state_nxt    = S_SQ_P;
        end
      end
      S_SQ_P: begin
        if (!sts.sq_busy) begin
          cmd.p_ld  = 1'b1;
          state_nxt = S_CT_MUL;
        end
      end
      S_CT_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CT;
        state_nxt   = S_CT_SQ;
      end
      S_CT_SQ: begin
        cmd.sq_start = 1'b1;
        cmd.sq_src   = SQ_SRC_TH;
        state_nxt    = S_SQ_T;
      end
      S_SQ_T: begin
        if (!sts.sq_busy) begin
          cmd.st_ld = 1'b1;
          state_nxt = S_MAG_MUL;
        end
      end
      S_MAG_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MAG;
        state_nxt   = S_MAG_RND;
      end
      S_MAG_RND: begin
        cmd.mag_ld = 1'b1;
        state_nxt  = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (!sts.sc_busy) begin
          state_nxt = S_X_MUL;
        end
      end
      S_X_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt   = S_X_RND;
      end
      S_X_RND: begin
        cmd.x_ld  = 1'b1;
        state_nxt = S_Y_MUL;
      end
      S_Y_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        state_nxt   = S_Y_RND;
      end
      S_Y_RND: begin
        cmd.y_ld  = 1'b1;
        state_nxt = S_Z_MUL;
      end
      S_Z_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Z;
        state_nxt   = S_Z_RND;
      end
      S_Z_RND: begin
        cmd.z_ld  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

FILE: sv/teis_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teis_dp
// Line table, search registers, shared multiplier, math units, output word.
// ----------------------------------------------------------------------------
module teis_dp #(
  parameter int TABLE_DEPTH   = teis_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = teis_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  teis_pkg::cmd_t    cmd,
  output teis_pkg::sts_t    sts,
  input  logic              cfg_wr_en,
  input  logic [23:0]       cfg_wr_data,
  input  logic [111:0]      in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [119:0]      out_tdata,
  output logic [0:0]        out_tuser
);

  import teis_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam int FRAC_SH = 32 - FRACTION_BITS;

  logic [23:0]   mass_r;
  logic [CW-1:0] count_r;
  logic [31:0]   wt_r;
  logic [31:0]   frac_e_r;
  logic [31:0]   ct_abs_r;
  logic          ct_neg_r;
  logic [31:0]   phase_r;
  logic          empty_r;
  logic [AW-1:0] lo_r;
  logic [AW-1:0] hi_r;
  logic [63:0]   prod_r;
  logic [23:0]   energy_r;
  logic [30:0]   p_r;
  logic [31:0]   st_r;
  logic [31:0]   mag_r;
  logic [31:0]   mx_r;
  logic [31:0]   my_r;
  logic [31:0]   mz_r;
  logic          out_valid_r;
  logic [119:0]  out_data_r;
  logic          out_empty_r;

  logic [15:0]   in_weight;
  logic [23:0]   in_energy;
  logic [31:0]   u_cos;
  logic [31:0]   u_phi;
  logic [31:0]   rs_new;
  logic          not_full;
  logic [AW-1:0] mid;
  logic [55:0]   rd_data;
  logic          rs_hit;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   sq_rad;
  logic          sq_busy;
  logic [31:0]   sq_root;
  logic          sc_busy;
  logic [31:0]   cos_q30;
  logic [31:0]   sin_q30;
  logic [31:0]   cos_abs;
  logic [31:0]   sin_abs;
  logic [64:0]   rnd30;
  logic [64:0]   rnd31;

  function automatic logic [31:0] sat_sign(input logic [64:0] m, input logic neg);
    logic [31:0] mc;
    mc = (m > 65'(MAG_MAX)) ? MAG_MAX : m[31:0];
    return neg ? -mc : mc;
  endfunction

  assign in_weight = in_tdata[15:0];
  assign in_energy = in_tdata[39:16];
  assign u_cos     = (32'(in_tdata[87:64]) & FRAC_MASK) << FRAC_SH;
  assign u_phi     = (32'(in_tdata[111:88]) & FRAC_MASK) << FRAC_SH;
  assign rs_new    = wt_r + 32'(in_weight);
  assign not_full  = count_r != CW'(TABLE_DEPTH);
  assign mid       = AW'(((AW + 1)'(lo_r) + (AW + 1)'(hi_r)) >> 1);
  assign rs_hit    = (64'(rd_data[31:0]) << FRACTION_BITS) >= prod_r;

  teis_ram #(
    .WIDTH (56),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.append && not_full),
    .wr_addr (AW'(count_r)),
    .wr_data ({in_energy, rs_new}),
    .rd_addr (mid),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r  <= MASS_RESET;
      count_r <= '0;
      wt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        mass_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        count_r <= '0;
        wt_r    <= '0;
      end else if (cmd.append && not_full) begin
        count_r <= count_r + CW'(1);
        wt_r    <= rs_new;
      end
    end
  end

  // Sample operands; cos(theta) = u - 2^31 is held as sign and magnitude.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      frac_e_r <= 32'(in_tdata[63:40]) & FRAC_MASK;
      ct_neg_r <= !u_cos[31];
      ct_abs_r <= u_cos[31] ? (u_cos - 32'h8000_0000) : (32'h8000_0000 - u_cos);
      phase_r  <= u_phi;
      empty_r  <= (count_r == '0);
    end
  end

  // Binary search for the first running sum at or above the target.
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= AW'(count_r - CW'(1));
    end else if (cmd.srch_upd) begin
      if (rs_hit) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid + AW'(1);
      end
    end
    if (cmd.sel_ld) begin
      energy_r <= rd_data[55:32];
    end
  end

  assign cos_abs = cos_q30[31] ? -cos_q30 : cos_q30;
  assign sin_abs = sin_q30[31] ? -sin_q30 : sin_q30;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_TGT: begin
        mul_a = frac_e_r;
        mul_b = wt_r;
      end
      MUL_Q: begin
        mul_a = 32'(mass_r);
        mul_b = 32'(energy_r);
      end
      MUL_CT: begin
        mul_a = ct_abs_r;
        mul_b = ct_abs_r;
      end
      MUL_MAG: begin
        mul_a = 32'(p_r);
        mul_b = st_r;
      end
      MUL_X: begin
        mul_a = mag_r;
        mul_b = cos_abs;
      end
      MUL_Y: begin
        mul_a = mag_r;
        mul_b = sin_abs;
      end
      MUL_Z: begin
        mul_a = 32'(p_r);
        mul_b = ct_abs_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
  end

  assign sq_rad = (cmd.sq_src == SQ_SRC_TH) ? ((64'd1 << 62) - prod_r)
                                            : {2'b00, prod_r[44:0], 17'd0};

  teis_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  teis_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sc_start),
    .phase   (phase_r),
    .busy    (sc_busy),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  assign rnd30 = (65'(prod_r) + (65'd1 << 29)) >> 30;
  assign rnd31 = (65'(prod_r) + (65'd1 << 30)) >> 31;

  always_ff @(posedge clk) begin
    if (cmd.p_sat) begin
      p_r <= MAG_MAX[30:0];
    end else if (cmd.p_ld) begin
      p_r <= sq_root[30:0];
    end
    if (cmd.st_ld) begin
      st_r <= sq_root;
    end
    if (cmd.mag_ld) begin
      mag_r <= rnd31[31:0];
    end
    if (cmd.x_ld) begin
      mx_r <= sat_sign(rnd30, cos_q30[31]);
    end
    if (cmd.y_ld) begin
      my_r <= sat_sign(rnd30, sin_q30[31]);
    end
    if (cmd.z_ld) begin
      mz_r <= sat_sign(rnd31, ct_neg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_empty_r <= empty_r;
      out_data_r  <= empty_r ? '0 : {energy_r, mz_r, my_r, mx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_empty_r;

  assign sts.count_zero = (count_r == '0);
  assign sts.lo_eq_hi   = (lo_r == hi_r);
  assign sts.q_big      = |prod_r[63:45];
  assign sts.sq_busy    = sq_busy;
  assign sts.sc_busy    = sc_busy;
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

FILE: sim/teis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teis_checker
// Watches both streams, predicts each sample result and compares it.
// ----------------------------------------------------------------------------
// Each accepted append or clear word updates a private copy of the spectrum
// table. A sample word produces an expected momentum word that is queued and
// compared field by field with the next accepted output word.
// ----------------------------------------------------------------------------
module teis_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           pending,
  output int           samples_seen
);
  import teis_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  // Field order matches {out_tdata, out_tuser}, highest bits first.
  typedef struct packed {
    logic [23:0] energy;
    logic [31:0] mz;
    logic [31:0] my;
    logic [31:0] mx;
    logic        empty;
  } momentum_t;

  logic [31:0] sum_tab [DEPTH];
  logic [23:0] energy_tab [DEPTH];
  int unsigned lines;
  logic [31:0] weight_sum;
  logic [23:0] mass;
  momentum_t   momentum_q [$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] b, int sh);
    return (a * b + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [31:0] sat_signed(logic [63:0] m, logic neg);
    logic [31:0] r;
    if (m > 64'(MAG_MAX)) m = 64'(MAG_MAX);
    r = m[31:0];
    return neg ? -r : r;
  endfunction

  // Quadrant plus a truncated Taylor series on the remaining angle, Q30.
  task automatic azimuth(input logic [31:0] ph, output longint cp, output longint sp);
    logic [63:0] r, a, t;
    longint c, s;
    r = {34'd0, ph[29:0]};
    a = (r * 64'd1686629713) >> 30;
    t = 64'd1 << 30;
    c = 64'sd1 << 30;
    s = 0;
    for (int k = 1; k <= 16; k++) begin
      t = ((t * a) >> 30) / k;
      if (k % 2 == 1) s = (k % 4 == 1) ? s + longint'(t) : s - longint'(t);
      else            c = (k % 4 == 0) ? c + longint'(t) : c - longint'(t);
    end
    if (c < 0) c = 0;
    if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
    if (s < 0) s = 0;
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    case (ph[31:30])
      2'd0: begin cp = c;  sp = s;  end
      2'd1: begin cp = -s; sp = c;  end
      2'd2: begin cp = -c; sp = -s; end
      default: begin cp = s; sp = -c; end
    endcase
  endtask

  task automatic predict_sample(input logic [111:0] d);
    momentum_t   m;
    logic [63:0] target, q, p, st, mag;
    logic [23:0] e;
    longint      ct, cph, sph;
    int unsigned sel;
    m = '0;
    if (lines == 0) begin
      m.empty = 1'b1;
    end else begin
      target = {40'd0, d[63:40]} * {32'd0, weight_sum};
      sel = lines - 1;
      for (int j = 0; j < lines; j++)
        if (({32'd0, sum_tab[j]} << 24) >= target) begin
          sel = j;
          break;
        end
      e = energy_tab[sel];
      q = {40'd0, mass} * {40'd0, e};
      p = (q >= (64'd1 << 45)) ? 64'(MAG_MAX) : int_sqrt(q << 17);
      ct = longint'({d[87:64], 8'd0}) - (64'sd1 << 31);
      st = int_sqrt((64'd1 << 62) - 64'(ct * ct));
      azimuth({d[111:88], 8'd0}, cph, sph);
      mag = scale_round(p, st, 31);
      m.mx = sat_signed(scale_round(mag, 64'(cph < 0 ? -cph : cph), 30), cph < 0);
      m.my = sat_signed(scale_round(mag, 64'(sph < 0 ? -sph : sph), 30), sph < 0);
      m.mz = sat_signed(scale_round(p, 64'(ct < 0 ? -ct : ct), 31), ct < 0);
      m.energy = e;
    end
    momentum_q.push_back(m);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = momentum_q.size();

  always @(posedge clk) begin
    momentum_t got, want;
    if (!rst_n) begin
      lines <= 0;
      weight_sum <= 0;
      mass <= MASS_RESET;
      fail_count <= 0;
      samples_seen <= 0;
      momentum_q.delete();
    end else begin
      if (cfg_wr_en) mass <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          FUNC_APPEND: if (lines < DEPTH) begin
            sum_tab[lines] = weight_sum + 32'(in_tdata[15:0]);
            energy_tab[lines] = in_tdata[39:16];
            weight_sum <= weight_sum + 32'(in_tdata[15:0]);
            lines <= lines + 1;
          end
          FUNC_CLEAR: begin
            lines <= 0;
            weight_sum <= 0;
          end
          FUNC_SAMPLE: predict_sample(in_tdata);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser};
        samples_seen <= samples_seen + 1;
        if (momentum_q.size() == 0) begin
          report_mismatch("pending results at output word", 32'd0, 32'd1);
        end else begin
          want = momentum_q.pop_front();
          if (got.mx !== want.mx) report_mismatch("mom_x", got.mx, want.mx);
          if (got.my !== want.my) report_mismatch("mom_y", got.my, want.my);
          if (got.mz !== want.mz) report_mismatch("mom_z", got.mz, want.mz);
          if (got.energy !== want.energy)
            report_mismatch("chosen_energy", 32'(got.energy), 32'(want.energy));
          if (got.empty !== want.empty)
            report_mismatch("table_empty", 32'(got.empty), 32'(want.empty));
        end
      end
    end
  end

endmodule

FILE: sim/tabulated_energy_isotropic_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabulated_energy_isotropic_sampler_tb
// Stimulus and verdict for the spectrum-line sampler.
// ----------------------------------------------------------------------------
// Directed words cover the empty table, zero weights, field extremes and the
// full table; random phases then mix appends, clears and samples under
// several mass settings with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tabulated_energy_isotropic_sampler_tb;
  import teis_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [23:0]  cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [0:0]   out_tuser;

  int  fail_count, pending, samples_seen;
  int  idle_cycles = 0;
  int  words_sent = 0;
  bit  hold_off = 1'b0;
  bit  stimulus_done = 1'b0;

  always #1 clk = ~clk;

  tabulated_energy_isotropic_sampler dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  teis_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .fail_count(fail_count),
    .pending(pending), .samples_seen(samples_seen)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [23:0] rnd24();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  // The word stays offered after its accepting edge until the next word
  // replaces it, a gap drops in_tvalid, or drain() idles the input.
  task automatic send_word(input logic [1:0] fn, input logic [111:0] d, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(input logic [15:0] w, input logic [23:0] e);
    send_word(FUNC_APPEND, {72'd0, e, w}, 1'b1);
  endtask

  task automatic send_sample(input logic [23:0] re, input logic [23:0] rc,
                             input logic [23:0] rp, input bit gaps);
    send_word(FUNC_SAMPLE, {rp, rc, re, 40'd0}, gaps);
  endtask

  // Idles the input and waits for all expected results to come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_mass(input logic [23:0] m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int n_words);
    int r;
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_line(($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom()), rnd24());
      else if (r < 92)
        send_sample(rnd24(), rnd24(), rnd24(), 1'b1);
      else if (r < 97)
        send_word(FUNC_CLEAR, 112'($urandom()), 1'b1);
      else
        send_word(FUNC_UNUSED, {$urandom(), $urandom(), $urandom(), 16'($urandom())},
                  1'b1);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if ($urandom_range(0, 99) < 8) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, zero weights, extremes, illegal code.
    send_sample(24'd0, 24'd0, 24'd0, 1'b0);
    send_word(FUNC_UNUSED, '1, 1'b0);
    send_line(16'd0, 24'd0);
    send_line(16'd0, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_sample(24'd0, 24'h800000, 24'h400000, 1'b0);
    send_line(16'hFFFF, 24'd1000);
    send_line(16'd1, 24'd5);
    send_sample(24'h7FFFFF, 24'h000001, 24'hC00000, 1'b0);
    send_sample(24'hFFFFFF, 24'h5A5A5A, 24'hA5A5A5, 1'b0);
    send_sample(24'd1, 24'h800000, 24'h800000, 1'b0);
    send_word(FUNC_CLEAR, '0, 1'b0);
    send_sample(24'h123456, 24'h654321, 24'h111111, 1'b0);
    write_mass(24'hFFFFFF);
    send_line(16'd7, 24'hFFFFFF);
    send_sample(24'h000000, 24'h000000, 24'h200000, 1'b0);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 24'h600000, 1'b0);
    write_mass(24'd0);
    send_sample(24'h400000, 24'h300000, 24'h700000, 1'b0);

    // Fill the table beyond its depth so appends get dropped.
    write_mass(24'd511);
    send_word(FUNC_CLEAR, '0, 1'b0);
    for (int i = 0; i < 1030; i++)
      send_word(FUNC_APPEND, {72'd0, 24'($urandom()), 16'($urandom_range(0, 3))}, 1'b0);
    for (int i = 0; i < 20; i++) send_sample(rnd24(), rnd24(), rnd24(), 1'b1);
    send_word(FUNC_CLEAR, '0, 1'b0);

    // Long receiver stall while the sender keeps offering words.
    write_mass(MASS_RESET);
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(60);
    join

    random_phase(100);
    write_mass(24'd1);
    random_phase(80);
    write_mass(24'(938272));
    random_phase(100);
    write_mass(24'($urandom()));
    random_phase(60);

    stimulus_done = 1'b1;
    drain();
    $display("Sent %0d input words, checked %0d sample results.", words_sent, samples_seen);
    $display("Covered empty and full tables, clears, idle codes and several mass settings.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
